>>> rtl/keyframe_vec3_sampler_unit_defines.svh
// assertion macros shared by the sampler rtl
`ifndef KEYFRAME_VEC3_SAMPLER_UNIT_DEFINES_SVH
`define KEYFRAME_VEC3_SAMPLER_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define KVS_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication under reset
`define KVS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/kvs_pkg.sv
package kvs_pkg;

    typedef struct packed {
        logic [31:0] t;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK0,
        ST_CHKL,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_PUSH
    } state_t;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam int DIV_STEPS = 16;

    function automatic logic [31:0] comp_sel(entry_t e, logic [1:0] c);
        logic [31:0] r;
        unique case (c)
            COMP_X:  r = e.x;
            COMP_Y:  r = e.y;
            default: r = e.z;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/keyframe_vec3_sampler_unit.sv
// Keyframe sampler: load beats (cmd 0) write one key (time, x, y, z) into a table of MAX_KEYS
// entries and give no result; sample beats (cmd 1) return the vector linearly interpolated at
// query_time over the first key_count keys (capped at MAX_KEYS), clamped to the first and last
// key. A load beat leaves in_ready high. A sample beat holds in_ready low while it checks the
// first key, then the last key (either check may end it with a clamp), then scans the table,
// reading one entry per cycle through the single read port, then a restoring divider forms the
// 16-bit factor one bit per cycle and one shared multiplier and adder handle the three
// components, each in a multiply state then an add state. The finished vector moves into an
// output register, so the next beat is taken while it waits there; a second finished vector
// waits until the first one is taken. The user must write key_count only while no sample is
// in progress, not enforced by the block; table entries must be loaded before they are sampled.
`include "keyframe_vec3_sampler_unit_defines.svh"

module keyframe_vec3_sampler_unit #(
    parameter int MAX_KEYS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [5:0]  key_index,
    input  logic [31:0] key_time,
    input  logic [31:0] key_x,
    input  logic [31:0] key_y,
    input  logic [31:0] key_z,
    input  logic [31:0] query_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(kvs_pkg::DIV_STEPS);

    kvs_pkg::entry_t mem [MAX_KEYS];
    kvs_pkg::entry_t rd_q;

    kvs_pkg::state_t state_reg, state_next;
    logic [6:0]      key_count_reg;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [AW-1:0]   last_w;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [1:0]      comp_reg, comp_next;
    logic            ov_reg, ov_next;

    logic [31:0]        t_reg, t_next;
    kvs_pkg::entry_t    a_reg, a_next;
    kvs_pkg::entry_t    b_reg, b_next;
    logic [31:0]        den_reg, den_next;
    logic [32:0]        rem_reg, rem_next;
    logic [15:0]        quot_reg, quot_next;
    logic signed [49:0] prod_reg, prod_next;
    logic [31:0]        res_reg [3];
    logic [31:0]        res_next [3];
    logic [31:0]        ox_reg, oy_reg, oz_reg;

    logic        accept;
    logic        wr_en;
    logic        push;
    logic [31:0] num_w, dif_w;
    logic [32:0] rem2_w;
    logic [31:0] a_comp_w, b_comp_w;
    logic signed [32:0] diff_w;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == kvs_pkg::ST_IDLE);
    assign wr_en    = accept && (cmd == kvs_pkg::CMD_LOAD) && (32'(key_index) < MAX_KEYS);
    assign push     = (state_reg == kvs_pkg::ST_PUSH) && (!ov_reg || out_ready);

    assign out_valid = ov_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;

    always_comb
    begin
        if (key_count_reg == 7'd0)
            last_w = '0;
        else if (32'(key_count_reg) > MAX_KEYS)
            last_w = AW'(MAX_KEYS - 1);
        else
            last_w = AW'(key_count_reg - 7'd1);
    end

    assign num_w    = t_reg - a_reg.t;
    assign dif_w    = rd_q.t - a_reg.t;
    assign rem2_w   = {rem_reg[31:0], 1'b0};
    assign a_comp_w = kvs_pkg::comp_sel(a_reg, comp_reg);
    assign b_comp_w = kvs_pkg::comp_sel(b_reg, comp_reg);
    assign diff_w   = $signed({b_comp_w[31], b_comp_w}) - $signed({a_comp_w[31], a_comp_w});

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        t_next     = t_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        ov_next    = (ov_reg && !out_ready) || push;

        unique case (state_reg)
            kvs_pkg::ST_IDLE:
            begin
                if (accept && (cmd == kvs_pkg::CMD_SAMPLE))
                begin
                    t_next     = query_time;
                    addr_next  = '0;
                    state_next = kvs_pkg::ST_CHK0;
                end
            end
            kvs_pkg::ST_CHK0:
            begin
                a_next = rd_q;
                if ((last_w == '0) || (t_reg < rd_q.t))
                begin
                    res_next[0] = rd_q.x;
                    res_next[1] = rd_q.y;
                    res_next[2] = rd_q.z;
                    state_next  = kvs_pkg::ST_PUSH;
                end
                else
                begin
                    addr_next  = last_w;
                    state_next = kvs_pkg::ST_CHKL;
                end
            end
            kvs_pkg::ST_CHKL:
            begin
                if (t_reg >= rd_q.t)
                begin
                    res_next[0] = rd_q.x;
                    res_next[1] = rd_q.y;
                    res_next[2] = rd_q.z;
                    state_next  = kvs_pkg::ST_PUSH;
                end
                else
                begin
                    addr_next  = AW'(1);
                    state_next = kvs_pkg::ST_SCAN;
                end
            end
            kvs_pkg::ST_SCAN:
            begin
                if ((addr_reg < last_w) && (t_reg >= rd_q.t))
                begin
                    a_next    = rd_q;
                    addr_next = addr_reg + AW'(1);
                end
                else
                begin
                    b_next    = rd_q;
                    quot_next = '0;
                    cnt_next  = '0;
                    if (num_w >= dif_w)
                    begin
                        rem_next = '0;
                        den_next = '1;
                    end
                    else
                    begin
                        rem_next = {1'b0, num_w};
                        den_next = dif_w;
                    end
                    state_next = kvs_pkg::ST_DIV;
                end
            end
            kvs_pkg::ST_DIV:
            begin
                if (rem2_w >= {1'b0, den_reg})
                begin
                    rem_next  = rem2_w - {1'b0, den_reg};
                    quot_next = {quot_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem2_w;
                    quot_next = {quot_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(kvs_pkg::DIV_STEPS - 1))
                begin
                    comp_next  = kvs_pkg::COMP_X;
                    state_next = kvs_pkg::ST_MUL;
                end
            end
            kvs_pkg::ST_MUL:
            begin
                prod_next  = diff_w * $signed({1'b0, quot_reg});
                state_next = kvs_pkg::ST_ADD;
            end
            kvs_pkg::ST_ADD:
            begin
                res_next[comp_reg] = a_comp_w + prod_reg[47:16];
                if (comp_reg == kvs_pkg::COMP_Z)
                    state_next = kvs_pkg::ST_PUSH;
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = kvs_pkg::ST_MUL;
                end
            end
            kvs_pkg::ST_PUSH:
            begin
                if (push)
                    state_next = kvs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kvs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kvs_pkg::ST_IDLE;
            key_count_reg <= 7'd1;
            ov_reg        <= 1'b0;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            comp_reg      <= kvs_pkg::COMP_X;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            addr_reg  <= addr_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            if (cfg_we)
                key_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        if (push)
        begin
            ox_reg <= res_reg[0];
            oy_reg <= res_reg[1];
            oz_reg <= res_reg[2];
        end
    end

    // key table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[AW'(key_index)] <= {key_time, key_x, key_y, key_z};
        rd_q <= mem[addr_next];
    end

    `KVS_ASSERT_NEXT(a_push_valid, push, out_valid, "result push did not raise out_valid")
    `KVS_ASSERT_NOW(a_scan_bound, state_reg == kvs_pkg::ST_SCAN, addr_reg <= last_w,
                    "scan address past last key")
    `KVS_ASSERT_NOW(a_div_rem, state_reg == kvs_pkg::ST_DIV, rem_reg < {1'b0, den_reg},
                    "divider remainder not below divisor")
    `KVS_ASSERT_NOW(a_comp_range,
                    (state_reg == kvs_pkg::ST_MUL) || (state_reg == kvs_pkg::ST_ADD),
                    comp_reg != 2'd3, "component index out of range")

endmodule
